// ===== rtl/epx_pkg.sv =====
`timescale 1ns / 1ps
package epx_pkg;

  localparam int MAX_FRAMES_DEF = 4096;
  localparam int SINE_ENTRIES_DEF = 256;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic [15:0] GAIN_MAX = 16'd32768;

  localparam logic [1:0] REG_POSITION = 2'd0;
  localparam logic [1:0] REG_TRIM_A = 2'd1;
  localparam logic [1:0] REG_TRIM_B = 2'd2;
  localparam logic [1:0] REG_MASTER = 2'd3;

  typedef struct packed {
    logic signed [15:0] deck_a_left;
    logic signed [15:0] deck_a_right;
    logic signed [15:0] deck_b_left;
    logic signed [15:0] deck_b_right;
    logic               last_of_block;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic               metrics_valid;
    logic [15:0]        block_rms;
    logic [15:0]        transition_smoothness;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] crossfader_position;
    logic [15:0]        trim_a;
    logic [15:0]        trim_b;
    logic [15:0]        master_level;
  } cfg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_GAIN_B, S_GAIN_A, S_AFA, S_ATA, S_BFB, S_BTB, S_ACC_S, S_MLO, S_MHI,
    S_ACC_V, S_ROUND, S_ELL, S_ERR, S_EACC, S_DIV_LOAD, S_DIV_RUN, S_SQRT_LOAD,
    S_SQRT_RUN, S_OUT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_GAIN_B, OP_GAIN_A, OP_MUL_AFA, OP_MUL_TA, OP_MUL_BFB,
    OP_MUL_TB, OP_ACC_S, OP_MUL_LO, OP_MUL_HI, OP_ACC_V, OP_ROUND, OP_MUL_LL,
    OP_MUL_RR, OP_ACC_E, OP_DIV_LOAD, OP_DIV_STEP, OP_SQRT_LOAD, OP_SQRT_STEP, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   ch;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_done;
    logic last;
    logic out_busy;
  } dp_status_t;

  function automatic logic [15:0] clamp_gain(input logic [15:0] g);
    return (g > GAIN_MAX) ? GAIN_MAX : g;
  endfunction

endpackage

// ===== rtl/epx_regs.sv =====
`timescale 1ns / 1ps
module epx_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output epx_pkg::cfg_t      cfg
);

  logic wr;

  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.crossfader_position <= 16'sd0;
      cfg.trim_a <= 16'd16384;
      cfg.trim_b <= 16'd16384;
      cfg.master_level <= 16'd16384;
    end else if (wr) begin
      case (paddr[3:2])
        epx_pkg::REG_POSITION: cfg.crossfader_position <= pwdata[15:0];
        epx_pkg::REG_TRIM_A:   cfg.trim_a <= pwdata[15:0];
        epx_pkg::REG_TRIM_B:   cfg.trim_b <= pwdata[15:0];
        epx_pkg::REG_MASTER:   cfg.master_level <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      epx_pkg::REG_POSITION: prdata = {16'd0, cfg.crossfader_position};
      epx_pkg::REG_TRIM_A:   prdata = {16'd0, cfg.trim_a};
      epx_pkg::REG_TRIM_B:   prdata = {16'd0, cfg.trim_b};
      epx_pkg::REG_MASTER:   prdata = {16'd0, cfg.master_level};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/epx_ctrl.sv =====
`timescale 1ns / 1ps
module epx_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  epx_pkg::dp_status_t  status,
  output epx_pkg::dp_cmd_t     cmd
);

  epx_pkg::ctrl_state_t state, state_next;
  logic ch, ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= epx_pkg::S_IDLE;
      ch <= 1'b0;
    end else begin
      state <= state_next;
      ch <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    ch_next = ch;
    case (state)
      epx_pkg::S_IDLE: begin
        ch_next = 1'b0;
        if (in_valid) state_next = epx_pkg::S_GAIN_B;
      end
      epx_pkg::S_GAIN_B:  state_next = epx_pkg::S_GAIN_A;
      epx_pkg::S_GAIN_A:  state_next = epx_pkg::S_AFA;
      epx_pkg::S_AFA:     state_next = epx_pkg::S_ATA;
      epx_pkg::S_ATA:     state_next = epx_pkg::S_BFB;
      epx_pkg::S_BFB:     state_next = epx_pkg::S_BTB;
      epx_pkg::S_BTB:     state_next = epx_pkg::S_ACC_S;
      epx_pkg::S_ACC_S:   state_next = epx_pkg::S_MLO;
      epx_pkg::S_MLO:     state_next = epx_pkg::S_MHI;
      epx_pkg::S_MHI:     state_next = epx_pkg::S_ACC_V;
      epx_pkg::S_ACC_V:   state_next = epx_pkg::S_ROUND;
      epx_pkg::S_ROUND: begin
        ch_next = !ch;
        state_next = ch ? epx_pkg::S_ELL : epx_pkg::S_AFA;
      end
      epx_pkg::S_ELL:     state_next = epx_pkg::S_ERR;
      epx_pkg::S_ERR:     state_next = epx_pkg::S_EACC;
      epx_pkg::S_EACC:    state_next = status.last ? epx_pkg::S_DIV_LOAD : epx_pkg::S_OUT;
      epx_pkg::S_DIV_LOAD: state_next = epx_pkg::S_DIV_RUN;
      epx_pkg::S_DIV_RUN: if (status.iter_done) state_next = epx_pkg::S_SQRT_LOAD;
      epx_pkg::S_SQRT_LOAD: state_next = epx_pkg::S_SQRT_RUN;
      epx_pkg::S_SQRT_RUN: if (status.iter_done) state_next = epx_pkg::S_OUT;
      epx_pkg::S_OUT:     if (!status.out_busy) state_next = epx_pkg::S_IDLE;
      default:            state_next = epx_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != epx_pkg::S_IDLE);
    cmd.ch = ch;
    case (state)
      epx_pkg::S_IDLE:      cmd.op = in_valid ? epx_pkg::OP_LOAD : epx_pkg::OP_NONE;
      epx_pkg::S_GAIN_B:    cmd.op = epx_pkg::OP_GAIN_B;
      epx_pkg::S_GAIN_A:    cmd.op = epx_pkg::OP_GAIN_A;
      epx_pkg::S_AFA:       cmd.op = epx_pkg::OP_MUL_AFA;
      epx_pkg::S_ATA:       cmd.op = epx_pkg::OP_MUL_TA;
      epx_pkg::S_BFB:       cmd.op = epx_pkg::OP_MUL_BFB;
      epx_pkg::S_BTB:       cmd.op = epx_pkg::OP_MUL_TB;
      epx_pkg::S_ACC_S:     cmd.op = epx_pkg::OP_ACC_S;
      epx_pkg::S_MLO:       cmd.op = epx_pkg::OP_MUL_LO;
      epx_pkg::S_MHI:       cmd.op = epx_pkg::OP_MUL_HI;
      epx_pkg::S_ACC_V:     cmd.op = epx_pkg::OP_ACC_V;
      epx_pkg::S_ROUND:     cmd.op = epx_pkg::OP_ROUND;
      epx_pkg::S_ELL:       cmd.op = epx_pkg::OP_MUL_LL;
      epx_pkg::S_ERR:       cmd.op = epx_pkg::OP_MUL_RR;
      epx_pkg::S_EACC:      cmd.op = epx_pkg::OP_ACC_E;
      epx_pkg::S_DIV_LOAD:  cmd.op = epx_pkg::OP_DIV_LOAD;
      epx_pkg::S_DIV_RUN:   cmd.op = epx_pkg::OP_DIV_STEP;
      epx_pkg::S_SQRT_LOAD: cmd.op = epx_pkg::OP_SQRT_LOAD;
      epx_pkg::S_SQRT_RUN:  cmd.op = epx_pkg::OP_SQRT_STEP;
      epx_pkg::S_OUT:       cmd.op = epx_pkg::OP_OUT;
      default:              cmd.op = epx_pkg::OP_NONE;
    endcase
  end

  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    (state == epx_pkg::S_DIV_RUN && !status.iter_done) |=> state == epx_pkg::S_DIV_RUN)
    else $error("divider left early");
  a_out_wait: assert property (@(posedge clk) disable iff (rst)
    (state == epx_pkg::S_OUT && status.out_busy) |=> state == epx_pkg::S_OUT)
    else $error("result dropped while output busy");

endmodule

// ===== rtl/epx_dp.sv =====
`timescale 1ns / 1ps
module epx_dp #(
  parameter int MAX_FRAMES = epx_pkg::MAX_FRAMES_DEF,
  parameter int SINE_TABLE_ENTRIES = epx_pkg::SINE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  epx_pkg::dp_cmd_t     cmd,
  output epx_pkg::dp_status_t  status,
  input  epx_pkg::cfg_t        cfg,
  input  epx_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output epx_pkg::out_item_t   out_data
);

  localparam int IW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int QW = 16 + IW;
  localparam int CW = $clog2(MAX_FRAMES + 1);

  logic [15:0] sine_tab [0:SINE_TABLE_ENTRIES];

  for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_tab
    // taylor series sine in Q30
    localparam longint unsigned X =
      (epx_pkg::HALF_PI_Q30 * 64'(k)) / 64'(SINE_TABLE_ENTRIES);
    localparam longint unsigned X2 = (X * X) >> 30;
    localparam longint unsigned T1 = ((X * X2) >> 30) / 64'd6;
    localparam longint unsigned T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam longint unsigned T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam longint unsigned T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam longint unsigned T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam longint unsigned T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam longint unsigned T7 = ((T6 * X2) >> 30) / 64'd210;
    localparam longint unsigned T8 = ((T7 * X2) >> 30) / 64'd272;
    localparam longint unsigned T9 = ((T8 * X2) >> 30) / 64'd342;
    localparam longint unsigned T10 = ((T9 * X2) >> 30) / 64'd420;
    localparam longint unsigned SUM =
      X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8 - T9 + T10;
    assign sine_tab[k] = 16'((SUM * 64'd16384 + (64'd1 << 29)) >> 30);
  end

  epx_pkg::in_item_t item;
  logic               last;
  logic [14:0]        fade_a, fade_b;
  logic signed [49:0] preg;
  logic signed [47:0] s_acc;
  logic signed [63:0] v_acc;
  logic signed [15:0] mix_l, mix_r;
  logic [47:0]        energy;
  logic [CW-1:0]      count;
  logic signed [15:0] prev_pos;
  logic [47:0]        dq;
  logic [CW:0]        den;
  logic [CW:0]        drem;
  logic [47:0]        sv;
  logic [23:0]        root;
  logic [25:0]        srem;
  logic [5:0]         iter;

  logic [15:0] ta, tb, mg;
  logic [15:0] u_phase;
  logic [QW-1:0] p_phase, q_phase;
  logic [IW-1:0] tab_i;
  logic [15:0] tab_f, tab_lo, tab_hi, tab_diff;
  logic [31:0] tab_prod;
  logic [15:0] gain_val;
  logic signed [32:0] opa;
  logic signed [16:0] opb;
  logic signed [63:0] v_rnd;
  logic signed [21:0] r22;
  logic signed [15:0] r_sat;
  logic [CW+1:0] dtry;
  logic [27:0] strial_in;
  logic [27:0] strial;
  logic signed [16:0] pos_d;
  logic [16:0] pos_ad;
  logic [19:0] six;
  logic [15:0] smooth;
  logic [CW:0] count_inc;

  assign ta = epx_pkg::clamp_gain(cfg.trim_a);
  assign tb = epx_pkg::clamp_gain(cfg.trim_b);
  assign mg = epx_pkg::clamp_gain(cfg.master_level);

  // phase and quarter-sine interpolation
  assign u_phase = {~cfg.crossfader_position[15], cfg.crossfader_position[14:0]};
  assign p_phase = QW'(u_phase) * QW'(SINE_TABLE_ENTRIES);
  assign q_phase = (cmd.op == epx_pkg::OP_GAIN_A) ?
                   ((QW'(SINE_TABLE_ENTRIES) << 16) - p_phase) : p_phase;
  assign tab_i = q_phase[QW-1:16];
  assign tab_f = q_phase[15:0];

  always_comb begin
    tab_lo = sine_tab[tab_i];
    tab_hi = tab_lo;
    if (tab_i < IW'(SINE_TABLE_ENTRIES)) tab_hi = sine_tab[tab_i + IW'(1)];
    tab_diff = (tab_hi > tab_lo) ? (tab_hi - tab_lo) : 16'd0;
    tab_prod = tab_diff * tab_f;
    gain_val = tab_lo + tab_prod[31:16];
  end

  // shared multiplier operand select
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.op)
      epx_pkg::OP_MUL_AFA: begin
        opa = 33'(cmd.ch ? item.deck_a_right : item.deck_a_left);
        opb = signed'({2'b00, fade_a});
      end
      epx_pkg::OP_MUL_TA: begin
        opa = preg[32:0];
        opb = signed'({1'b0, ta});
      end
      epx_pkg::OP_MUL_BFB: begin
        opa = 33'(cmd.ch ? item.deck_b_right : item.deck_b_left);
        opb = signed'({2'b00, fade_b});
      end
      epx_pkg::OP_MUL_TB: begin
        opa = preg[32:0];
        opb = signed'({1'b0, tb});
      end
      epx_pkg::OP_MUL_LO: begin
        opa = signed'({9'd0, s_acc[23:0]});
        opb = signed'({1'b0, mg});
      end
      epx_pkg::OP_MUL_HI: begin
        opa = 33'(signed'(s_acc[47:24]));
        opb = signed'({1'b0, mg});
      end
      epx_pkg::OP_MUL_LL: begin
        opa = 33'(mix_l);
        opb = 17'(mix_l);
      end
      epx_pkg::OP_MUL_RR: begin
        opa = 33'(mix_r);
        opb = 17'(mix_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    v_rnd = v_acc + (64'sd1 <<< 41);
    r22 = v_rnd[63:42];
    if (r22 > 22'sd32767) r_sat = 16'sd32767;
    else if (r22 < -22'sd32768) r_sat = -16'sd32768;
    else r_sat = r22[15:0];
  end

  assign dtry = {drem, dq[47]};
  assign strial_in = {srem, sv[47:46]};
  assign strial = {2'b00, root, 2'b01};

  always_comb begin
    pos_d = 17'(cfg.crossfader_position) - 17'(prev_pos);
    pos_ad = pos_d[16] ? 17'(-pos_d) : 17'(pos_d);
    six = (20'(pos_ad) << 2) + (20'(pos_ad) << 1);
    smooth = (six >= 20'd32768) ? 16'd0 : 16'(20'd32768 - six);
  end

  assign count_inc = {1'b0, count} + (CW + 1)'(1);

  assign status.iter_done = (iter == 6'd0);
  assign status.last = last;
  assign status.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy <= '0;
      count <= '0;
      prev_pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && cmd.op != epx_pkg::OP_OUT) out_valid <= 1'b0;
      case (cmd.op)
        epx_pkg::OP_MUL_RR: energy <= energy + preg[47:0];
        epx_pkg::OP_ACC_E: begin
          energy <= energy + preg[47:0];
          count <= count_inc[CW-1:0];
        end
        epx_pkg::OP_OUT: begin
          if (!status.out_busy) begin
            out_valid <= 1'b1;
            if (last) begin
              energy <= '0;
              count <= '0;
              prev_pos <= cfg.crossfader_position;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      epx_pkg::OP_LOAD: begin
        item <= in_data;
        last <= in_data.last_of_block || (count_inc >= (CW + 1)'(MAX_FRAMES));
      end
      epx_pkg::OP_GAIN_B: fade_b <= gain_val[14:0];
      epx_pkg::OP_GAIN_A: fade_a <= gain_val[14:0];
      epx_pkg::OP_MUL_AFA, epx_pkg::OP_MUL_TA, epx_pkg::OP_MUL_TB,
      epx_pkg::OP_MUL_LO, epx_pkg::OP_MUL_LL, epx_pkg::OP_MUL_RR: preg <= opa * opb;
      epx_pkg::OP_MUL_BFB: begin
        s_acc <= preg[47:0];
        preg <= opa * opb;
      end
      epx_pkg::OP_ACC_S: s_acc <= s_acc + preg[47:0];
      epx_pkg::OP_MUL_HI: begin
        v_acc <= 64'(preg);
        preg <= opa * opb;
      end
      epx_pkg::OP_ACC_V: v_acc <= v_acc + (64'(preg) <<< 24);
      epx_pkg::OP_ROUND: begin
        if (cmd.ch) mix_r <= r_sat;
        else mix_l <= r_sat;
      end
      epx_pkg::OP_DIV_LOAD: begin
        dq <= energy;
        drem <= '0;
        den <= {count, 1'b0};
        iter <= 6'd47;
      end
      epx_pkg::OP_DIV_STEP: begin
        if (dtry >= {1'b0, den}) begin
          drem <= (CW + 1)'(dtry - {1'b0, den});
          dq <= {dq[46:0], 1'b1};
        end else begin
          drem <= dtry[CW:0];
          dq <= {dq[46:0], 1'b0};
        end
        iter <= iter - 6'd1;
      end
      epx_pkg::OP_SQRT_LOAD: begin
        sv <= dq;
        root <= '0;
        srem <= '0;
        iter <= 6'd23;
      end
      epx_pkg::OP_SQRT_STEP: begin
        if (strial_in >= strial) begin
          srem <= 26'(strial_in - strial);
          root <= {root[22:0], 1'b1};
        end else begin
          srem <= strial_in[25:0];
          root <= {root[22:0], 1'b0};
        end
        sv <= {sv[45:0], 2'b00};
        iter <= iter - 6'd1;
      end
      epx_pkg::OP_OUT: begin
        if (!status.out_busy) begin
          out_data.mix_left <= mix_l;
          out_data.mix_right <= mix_r;
          out_data.metrics_valid <= last;
          out_data.block_rms <= last ? root[15:0] : 16'd0;
          out_data.transition_smoothness <= last ? smooth : 16'd0;
        end
      end
      default: ;
    endcase
  end

  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == epx_pkg::OP_OUT && !status.out_busy && last) |=>
      (count == '0 && energy == '0))
    else $error("block state not cleared");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && cmd.op != epx_pkg::OP_OUT) |=> $stable(out_data))
    else $error("stalled result changed");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, count} <= (CW + 1)'(MAX_FRAMES))
    else $error("frame count overflow");

endmodule

// ===== rtl/equal_power_stereo_crossfade_mixer_top.sv =====
`timescale 1ns / 1ps
// Equal-power stereo crossfade mixer.
// Input channel in_valid/in_stall/in_data carries one stereo frame of each deck
// plus the block-end flag; output channel out_valid/out_stall/out_data carries
// the saturated mix and, on block ends, rms and smoothness metrics.
// Crossfader, trims and master level are written over the APB port; the user
// must write them only while no frame is in flight; the block does not check.
// One frame goes through a shared 33x17 multiplier in a fixed sequence, and a
// new frame is taken only after the result of the previous one is presented.
// A block-end frame adds a bit-serial restoring divider and square root, each
// started by its own load state.
// Reset (synchronous) restores register defaults and clears energy, frame
// count and stored crossfader; no item is pending after reset.
// While the receiver stalls, the finished result holds; the next frame may be
// accepted and computed, and waits to be presented until the output is free.
module equal_power_stereo_crossfade_mixer_top #(
  parameter int MAX_FRAMES = epx_pkg::MAX_FRAMES_DEF,
  parameter int SINE_TABLE_ENTRIES = epx_pkg::SINE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  epx_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output epx_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  epx_pkg::cfg_t       cfg;
  epx_pkg::dp_cmd_t    cmd;
  epx_pkg::dp_status_t status;

  epx_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  epx_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .status(status), .cmd(cmd)
  );

  epx_dp #(
    .MAX_FRAMES(MAX_FRAMES),
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .cfg(cfg),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

endmodule
